// File: rtl/dmsc_pkg.sv
// dmsc_pkg.sv: shared types, codes and helpers of the door motion state controller
`default_nettype none

package dmsc_pkg;

    // beat widths on the stream and configuration ports
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned S_USER_W = 3;
    localparam int unsigned M_DATA_W = 80;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned PDATA_W  = 32;

    // request kinds
    typedef enum logic [2:0] {
        REQ_MARK_CLOSED = 3'd0,
        REQ_MARK_OPEN   = 3'd1,
        REQ_SET_POS     = 3'd2,
        REQ_OPEN        = 3'd3,
        REQ_CLOSE       = 3'd4,
        REQ_STOP        = 3'd5,
        REQ_TARGET      = 3'd6,
        REQ_FAULT       = 3'd7
    } req_t;

    // result codes
    typedef enum logic [2:0] {
        RC_OK        = 3'd0,
        RC_INVALID   = 3'd1,
        RC_BUSY      = 3'd2,
        RC_FAULT     = 3'd3,
        RC_UNTRUSTED = 3'd4
    } rc_t;

    // door state, one-hot
    typedef enum logic [6:0] {
        DOOR_UNKNOWN = 7'b000_0001,
        DOOR_CLOSED  = 7'b000_0010,
        DOOR_OPEN    = 7'b000_0100,
        DOOR_PARTIAL = 7'b000_1000,
        DOOR_OPENING = 7'b001_0000,
        DOOR_CLOSING = 7'b010_0000,
        DOOR_FAULT   = 7'b100_0000
    } door_t;

    // door state codes as reported on the result beat
    localparam logic [2:0] ST_UNKNOWN = 3'd0;
    localparam logic [2:0] ST_CLOSED  = 3'd1;
    localparam logic [2:0] ST_OPEN    = 3'd2;
    localparam logic [2:0] ST_PARTIAL = 3'd3;
    localparam logic [2:0] ST_OPENING = 3'd4;
    localparam logic [2:0] ST_CLOSING = 3'd5;
    localparam logic [2:0] ST_FAULT   = 3'd6;

    // active command
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_CLOSE = 2'd2
    } cmd_t;

    // last stop reason
    typedef enum logic [1:0] {
        STOP_NONE   = 2'd0,
        STOP_TARGET = 2'd1,
        STOP_USER   = 2'd2,
        STOP_FAULT  = 2'd3
    } stop_t;

    localparam logic [1:0] TRUST_NONE = 2'd0;
    localparam logic [1:0] TRUST_SET  = 2'd1;
    localparam logic [3:0] FAULT_NONE = 4'd0;

    // configuration register indexes
    localparam logic [1:0] REG_OPEN_TARGET = 2'd0;
    localparam logic [1:0] REG_CLOSED_POS  = 2'd1;
    localparam logic [1:0] REG_MAX_PULSES  = 2'd2;
    localparam logic [1:0] REG_MAX_MS      = 2'd3;

    // supervisor status kept between events
    typedef struct packed {
        door_t              door;
        logic signed [31:0] position;
        logic signed [31:0] target;
        cmd_t               cmd;
        logic [1:0]         trust;
        stop_t              stop;
        logic [3:0]         fault;
    } status_t;

    // configuration seen by the event logic
    typedef struct packed {
        logic signed [31:0] open_target;
        logic signed [31:0] closed_pos;
        logic               cfg_ok;
    } cfg_t;

    // one-hot door state to its reported code
    function automatic logic [2:0] door_code(input door_t d);
        logic [2:0] code;
        code = ST_UNKNOWN;
        unique case (d)
            DOOR_UNKNOWN: code = ST_UNKNOWN;
            DOOR_CLOSED:  code = ST_CLOSED;
            DOOR_OPEN:    code = ST_OPEN;
            DOOR_PARTIAL: code = ST_PARTIAL;
            DOOR_OPENING: code = ST_OPENING;
            DOOR_CLOSING: code = ST_CLOSING;
            DOOR_FAULT:   code = ST_FAULT;
            default:      code = ST_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/dmsc_step.sv
// dmsc_step.sv: event decode and status update for one request
`default_nettype none

module dmsc_step
    import dmsc_pkg::*;
(
    input  wire status_t            cur,
    input  wire cfg_t               cfg,
    input  wire req_t               req,
    input  wire logic signed [31:0] pos_in,
    input  wire logic [1:0]         trust_in,
    input  wire logic [3:0]         fault_in,
    output status_t                 nxt,
    output rc_t                     rc
);

    logic running;

    assign running = (cur.door == DOOR_OPENING) || (cur.door == DOOR_CLOSING);

    // apply one event to the status
    always_comb begin
        nxt = cur;
        rc  = RC_OK;
        unique case (req)
            REQ_MARK_CLOSED, REQ_MARK_OPEN: begin
                if (!cfg.cfg_ok) begin
                    rc = RC_INVALID;
                end else if (running) begin
                    rc = RC_BUSY;
                end else begin
                    nxt.position = (req == REQ_MARK_OPEN) ? cfg.open_target : cfg.closed_pos;
                    nxt.target   = nxt.position;
                    nxt.door     = (req == REQ_MARK_OPEN) ? DOOR_OPEN : DOOR_CLOSED;
                    nxt.cmd      = CMD_NONE;
                    nxt.trust    = TRUST_SET;
                    nxt.stop     = STOP_TARGET;
                    nxt.fault    = FAULT_NONE;
                end
            end
            REQ_SET_POS: begin
                if (!cfg.cfg_ok) begin
                    rc = RC_INVALID;
                end else if (running) begin
                    rc = RC_BUSY;
                end else begin
                    nxt.position = pos_in;
                    nxt.target   = pos_in;
                    nxt.trust    = trust_in;
                    nxt.cmd      = CMD_NONE;
                    nxt.fault    = FAULT_NONE;
                    priority if (trust_in == TRUST_NONE) begin
                        nxt.door = DOOR_UNKNOWN;
                    end else if (pos_in <= cfg.closed_pos) begin
                        nxt.door = DOOR_CLOSED;
                    end else if (pos_in >= cfg.open_target) begin
                        nxt.door = DOOR_OPEN;
                    end else begin
                        nxt.door = DOOR_PARTIAL;
                    end
                end
            end
            REQ_OPEN, REQ_CLOSE: begin
                if (!cfg.cfg_ok) begin
                    rc = RC_INVALID;
                end else if (cur.door == DOOR_FAULT) begin
                    rc = RC_FAULT;
                end else if (running) begin
                    rc = RC_BUSY;
                end else if (cur.trust == TRUST_NONE) begin
                    rc = RC_UNTRUSTED;
                end else begin
                    nxt.cmd    = (req == REQ_OPEN) ? CMD_OPEN : CMD_CLOSE;
                    nxt.door   = (req == REQ_OPEN) ? DOOR_OPENING : DOOR_CLOSING;
                    nxt.target = (req == REQ_OPEN) ? cfg.open_target : cfg.closed_pos;
                    nxt.stop   = STOP_NONE;
                end
            end
            REQ_STOP, REQ_TARGET: begin
                if (!running) begin
                    rc = RC_INVALID;
                end else begin
                    nxt.position = pos_in;
                    nxt.target   = pos_in;
                    nxt.cmd      = CMD_NONE;
                    nxt.trust    = TRUST_SET;
                    if (req == REQ_STOP) begin
                        nxt.door = DOOR_PARTIAL;
                        nxt.stop = STOP_USER;
                    end else begin
                        nxt.stop  = STOP_TARGET;
                        nxt.fault = FAULT_NONE;
                        nxt.door  = (cur.cmd == CMD_OPEN) ? DOOR_OPEN : DOOR_CLOSED;
                    end
                end
            end
            REQ_FAULT: begin
                nxt.door  = DOOR_FAULT;
                nxt.cmd   = CMD_NONE;
                nxt.fault = fault_in;
                nxt.stop  = STOP_FAULT;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/door_motion_state_controller_core.sv
// door_motion_state_controller_core.sv: top level of the door motion state controller
// A taken request beat waits in the input register, then passes the event logic into the
// result register, where its result beat is offered; a held result stage stalls the input.
// Throughput: one request per cycle while m_tready does not hold the result stage, set by the status update loop.
// Reset: synchronous, active low; configuration and beat valids clear to zero, status to an unknown, untrusted door.
`default_nettype none

module door_motion_state_controller_core
    import dmsc_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    // request channel
    input  wire                 s_tvalid,
    output logic                s_tready,
    // [31:0] position_in, [33:32] trust_in, [37:34] fault_code_in, [39:38] zero
    input  wire [S_DATA_W-1:0]  s_tdata,
    // [2:0] req_type
    input  wire [S_USER_W-1:0]  s_tuser,
    // result channel
    output logic                m_tvalid,
    input  wire                 m_tready,
    // [2:0] result_code, [5:3] door_state_out, [37:6] position_out,
    // [69:38] target_out, [71:70] command_out, [73:72] trust_out,
    // [75:74] stop_reason_out, [79:76] fault_out
    output logic [M_DATA_W-1:0] m_tdata,
    // configuration port
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [ADDR_W-1:0]    paddr,
    input  wire [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    // configuration registers
    logic signed [31:0] open_target_reg;
    logic signed [31:0] closed_pos_reg;
    logic [30:0]        max_pulses_reg;
    logic [31:0]        max_ms_reg;
    logic               cfg_wr;
    logic [1:0]         cfg_idx;
    cfg_t               cfg;

    // input stage
    logic               in_valid_reg, in_valid_next;
    req_t               in_req_reg;
    logic signed [31:0] in_pos_reg;
    logic [1:0]         in_trust_reg;
    logic [3:0]         in_fault_reg;
    logic               s_take;
    logic               advance;

    // status and result stage
    status_t            status_reg, status_next;
    rc_t                rc;
    logic               out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;

    // apb access
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        unique case (cfg_idx)
            REG_OPEN_TARGET: prdata = open_target_reg;
            REG_CLOSED_POS:  prdata = closed_pos_reg;
            REG_MAX_PULSES:  prdata = {1'b0, max_pulses_reg};
            REG_MAX_MS:      prdata = max_ms_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_target_reg <= '0;
            closed_pos_reg  <= '0;
            max_pulses_reg  <= '0;
            max_ms_reg      <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_OPEN_TARGET: open_target_reg <= pwdata;
                REG_CLOSED_POS:  closed_pos_reg  <= pwdata;
                REG_MAX_PULSES:  max_pulses_reg  <= pwdata[30:0];
                REG_MAX_MS:      max_ms_reg      <= pwdata;
            endcase
        end
    end

    // configuration validity
    assign cfg.open_target = open_target_reg;
    assign cfg.closed_pos  = closed_pos_reg;
    assign cfg.cfg_ok      = (open_target_reg > closed_pos_reg) &&
                             (max_pulses_reg != '0) && (max_ms_reg != '0);

    // handshake: the input stage moves on when the result stage is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // request beat capture
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_req_reg   <= req_t'(s_tuser[2:0]);
            in_pos_reg   <= s_tdata[31:0];
            in_trust_reg <= s_tdata[33:32];
            in_fault_reg <= s_tdata[37:34];
        end
    end

    // event logic
    dmsc_step u_step (
        .cur      (status_reg),
        .cfg      (cfg),
        .req      (in_req_reg),
        .pos_in   (in_pos_reg),
        .trust_in (in_trust_reg),
        .fault_in (in_fault_reg),
        .nxt      (status_next),
        .rc       (rc)
    );

    // status commits as the beat enters the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= '{door: DOOR_UNKNOWN, position: '0, target: '0, cmd: CMD_NONE,
                            trust: TRUST_NONE, stop: STOP_NONE, fault: FAULT_NONE};
        end else if (advance) begin
            status_reg <= status_next;
        end
    end

    // result stage
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {status_next.fault, status_next.stop, status_next.trust,
                             status_next.cmd, status_next.target, status_next.position,
                             door_code(status_next.door), rc};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: bench/door_status_scoreboard_pkg.sv
// door_status_scoreboard_pkg.sv: status predictor and result scoreboard for the door controller bench
`timescale 1ns / 100ps

package door_status_scoreboard_pkg;
    import dmsc_pkg::*;

    // one status beat as the block should report it
    typedef struct {
        rc_t         rc;
        logic [2:0]  door;
        logic [31:0] position;
        logic [31:0] target;
        cmd_t        cmd;
        logic [1:0]  trust;
        stop_t       stop;
        logic [3:0]  fault;
    } door_status_t;

    class door_status_scoreboard;
        // configuration copy
        logic signed [31:0] open_target;
        logic signed [31:0] closed_pos;
        logic [30:0]        max_pulses;
        logic [31:0]        max_ms;

        // supervisor status copy
        logic [2:0]         door;
        logic signed [31:0] position;
        logic signed [31:0] target;
        cmd_t               cmd;
        logic [1:0]         trust;
        stop_t              stop;
        logic [3:0]         fault;

        door_status_t status_due_q[$];
        int unsigned  errors;
        int unsigned  beats;

        function new();
            open_target = '0;
            closed_pos  = '0;
            max_pulses  = '0;
            max_ms      = '0;
            door        = ST_UNKNOWN;
            position    = '0;
            target      = '0;
            cmd         = CMD_NONE;
            trust       = TRUST_NONE;
            stop        = STOP_NONE;
            fault       = FAULT_NONE;
            errors      = 0;
            beats       = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_OPEN_TARGET: open_target = value;
                REG_CLOSED_POS:  closed_pos  = value;
                REG_MAX_PULSES:  max_pulses  = value[30:0];
                REG_MAX_MS:      max_ms      = value;
                default: ;
            endcase
        endfunction

        function bit configured();
            return (open_target > closed_pos) && (max_pulses != 0) && (max_ms != 0);
        endfunction

        function bit running();
            return (door == ST_OPENING) || (door == ST_CLOSING);
        endfunction

        function int unsigned pending();
            return status_due_q.size();
        endfunction

        // apply one accepted event to the status copy and queue the beat it should give
        function void note_event(req_t req, logic signed [31:0] pos_in,
                                 logic [1:0] trust_in, logic [3:0] reason);
            rc_t          rc;
            cmd_t         done;
            door_status_t due;
            rc = RC_OK;
            case (req)
                REQ_MARK_CLOSED, REQ_MARK_OPEN: begin
                    if (!configured()) begin
                        rc = RC_INVALID;
                    end else if (running()) begin
                        rc = RC_BUSY;
                    end else begin
                        position = (req == REQ_MARK_CLOSED) ? closed_pos : open_target;
                        target   = position;
                        door     = (req == REQ_MARK_CLOSED) ? ST_CLOSED : ST_OPEN;
                        cmd      = CMD_NONE;
                        trust    = TRUST_SET;
                        stop     = STOP_TARGET;
                        fault    = FAULT_NONE;
                    end
                end
                REQ_SET_POS: begin
                    if (!configured()) begin
                        rc = RC_INVALID;
                    end else if (running()) begin
                        rc = RC_BUSY;
                    end else begin
                        position = pos_in;
                        target   = pos_in;
                        trust    = trust_in;
                        cmd      = CMD_NONE;
                        fault    = FAULT_NONE;
                        if (trust_in == TRUST_NONE)
                            door = ST_UNKNOWN;
                        else if (pos_in <= closed_pos)
                            door = ST_CLOSED;
                        else if (pos_in >= open_target)
                            door = ST_OPEN;
                        else
                            door = ST_PARTIAL;
                    end
                end
                REQ_OPEN, REQ_CLOSE: begin
                    // refusal order: unconfigured, fault, running, untrusted
                    if (!configured()) begin
                        rc = RC_INVALID;
                    end else if (door == ST_FAULT) begin
                        rc = RC_FAULT;
                    end else if (running()) begin
                        rc = RC_BUSY;
                    end else if (trust == TRUST_NONE) begin
                        rc = RC_UNTRUSTED;
                    end else begin
                        cmd    = (req == REQ_OPEN) ? CMD_OPEN : CMD_CLOSE;
                        door   = (req == REQ_OPEN) ? ST_OPENING : ST_CLOSING;
                        target = (req == REQ_OPEN) ? open_target : closed_pos;
                        stop   = STOP_NONE;
                    end
                end
                REQ_STOP, REQ_TARGET: begin
                    if (!running()) begin
                        rc = RC_INVALID;
                    end else begin
                        done     = cmd;
                        position = pos_in;
                        target   = pos_in;
                        cmd      = CMD_NONE;
                        trust    = TRUST_SET;
                        if (req == REQ_STOP) begin
                            door = ST_PARTIAL;
                            stop = STOP_USER;
                        end else begin
                            stop  = STOP_TARGET;
                            fault = FAULT_NONE;
                            door  = (done == CMD_OPEN) ? ST_OPEN : ST_CLOSED;
                        end
                    end
                end
                default: begin
                    // fault is taken in any state, reason zero included
                    door  = ST_FAULT;
                    cmd   = CMD_NONE;
                    fault = reason;
                    stop  = STOP_FAULT;
                end
            endcase
            due.rc       = rc;
            due.door     = door;
            due.position = position;
            due.target   = target;
            due.cmd      = cmd;
            due.trust    = trust;
            due.stop     = stop;
            due.fault    = fault;
            status_due_q.push_back(due);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] result beat %0d: %s", $time, beats, what);
            errors++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        endtask

        // compare one taken result beat with the oldest status due
        task check_status(logic [M_DATA_W-1:0] beat);
            door_status_t due;
            beats++;
            if (status_due_q.size() == 0) begin
                report_mismatch("result beat with no event waiting");
                return;
            end
            due = status_due_q.pop_front();
            compare_field("result_code",     beat[2:0],   due.rc);
            compare_field("door_state_out",  beat[5:3],   due.door);
            compare_field("position_out",    beat[37:6],  due.position);
            compare_field("target_out",      beat[69:38], due.target);
            compare_field("command_out",     beat[71:70], due.cmd);
            compare_field("trust_out",       beat[73:72], due.trust);
            compare_field("stop_reason_out", beat[75:74], due.stop);
            compare_field("fault_out",       beat[79:76], due.fault);
        endtask

        task report_leftover();
            if (status_due_q.size() != 0)
                report_mismatch($sformatf("%0d result beats never arrived", status_due_q.size()));
        endtask
    endclass

endpackage

// File: bench/door_motion_state_controller_core_test.sv
// door_motion_state_controller_core_test.sv: self-checking bench for the door motion state controller
`timescale 1ns / 100ps

module door_motion_state_controller_core_test;
    import dmsc_pkg::*;
    import door_status_scoreboard_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SETTLE_TICKS = 4;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]  pwdata   = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    door_status_scoreboard sb;
    bit                    calm = 1'b0;
    int unsigned           sent_count = 0;
    int unsigned           cycles = 0;

    door_motion_state_controller_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side back-pressure, none during the calm stretch
    always @(posedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
    end

    // watch both channels and the register port at every edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (psel && penable && pwrite && pready)
                sb.write_register(paddr[3:2], pwdata);
            if (s_tvalid && s_tready)
                sb.note_event(req_t'(s_tuser), s_tdata[31:0], s_tdata[33:32], s_tdata[37:34]);
            if (m_tvalid && m_tready)
                sb.check_status(m_tdata);
        end
    end

    // one request beat, with a random gap in front of it
    task automatic send_event(req_t req, logic [31:0] pos, logic [1:0] trust, logic [3:0] reason);
        int unsigned gap;
        gap = 0;
        if (!calm) begin
            if ($urandom_range(99) < 12)
                gap = $urandom_range(1, 3);
            else if ($urandom_range(199) == 0)
                gap = $urandom_range(8, 30);
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, reason, trust, pos};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    // hold the sender until every due result has come back
    task automatic settle_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_setting(logic [31:0] open_t, logic [31:0] closed_p,
                                logic [31:0] pulses, logic [31:0] ms);
        apb_write(REG_OPEN_TARGET, open_t);
        apb_write(REG_CLOSED_POS, closed_p);
        apb_write(REG_MAX_PULSES, pulses);
        apb_write(REG_MAX_MS, ms);
    endtask

    // mostly a valid open/closed pair, wide or narrow
    task automatic load_random_setting();
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom();
        b = $urandom();
        if ($urandom_range(1) == 0) begin
            b = a + $urandom_range(1, 2000);
        end
        if ($signed(b) > $signed(a))
            load_setting(b, a, $urandom(), $urandom());
        else
            load_setting(a, b, $urandom(), $urandom());
    endtask

    // positions near the configured ends, the extremes, or anywhere
    function automatic logic [31:0] pick_position();
        int offset;
        offset = int'($urandom_range(4)) - 2;
        case ($urandom_range(5))
            0: return sb.closed_pos + offset;
            1: return sb.open_target + offset;
            2: return sb.closed_pos + $urandom_range(0, 1000);
            3: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // establish a position, run a move, then end it in one of several ways
    task automatic move_sequence();
        req_t intruder;
        case ($urandom_range(9))
            0, 1, 2: send_event(REQ_MARK_CLOSED, $urandom(), 2'($urandom_range(3)),
                                4'($urandom_range(15)));
            3, 4:    send_event(REQ_MARK_OPEN, $urandom(), 2'($urandom_range(3)),
                                4'($urandom_range(15)));
            5:       send_event(REQ_SET_POS, pick_position(), TRUST_NONE,
                                4'($urandom_range(15)));
            default: send_event(REQ_SET_POS, pick_position(), 2'($urandom_range(1, 3)),
                                4'($urandom_range(15)));
        endcase
        send_event($urandom_range(1) ? REQ_OPEN : REQ_CLOSE, $urandom(), 2'($urandom_range(3)),
                   4'($urandom_range(15)));
        if ($urandom_range(99) < 30) begin
            intruder = req_t'($urandom_range(REQ_MARK_CLOSED, REQ_CLOSE));
            send_event(intruder, pick_position(), 2'($urandom_range(3)),
                       4'($urandom_range(15)));
        end
        case ($urandom_range(9))
            0:       send_event(REQ_FAULT, $urandom(), 2'($urandom_range(3)),
                                4'($urandom_range(15)));
            1, 2, 3: send_event(REQ_STOP, pick_position(), 2'($urandom_range(3)),
                                4'($urandom_range(15)));
            default: send_event(REQ_TARGET, pick_position(), 2'($urandom_range(3)),
                                4'($urandom_range(15)));
        endcase
        if ($urandom_range(99) < 10)
            send_event($urandom_range(1) ? REQ_STOP : REQ_TARGET, $urandom(),
                       2'($urandom_range(3)), 4'($urandom_range(15)));
    endtask

    task automatic run_random(int unsigned count);
        int unsigned stop_at;
        stop_at = sent_count + count;
        while (sent_count < stop_at) begin
            if ($urandom_range(99) < 70)
                move_sequence();
            else
                send_event(req_t'($urandom_range(7)), $urandom(), 2'($urandom_range(3)),
                           4'($urandom_range(15)));
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unconfigured: everything but fault is refused
        send_event(REQ_MARK_CLOSED, 32'd0, 2'd0, 4'd0);
        send_event(REQ_SET_POS, 32'd12, 2'd1, 4'd0);
        send_event(REQ_OPEN, 32'd0, 2'd0, 4'd0);
        send_event(REQ_STOP, 32'd3, 2'd0, 4'd0);
        send_event(REQ_FAULT, 32'd0, 2'd0, 4'd0);
        send_event(REQ_CLOSE, 32'd0, 2'd0, 4'd0);
        settle_results();

        // simple setting with the limit registers at their maxima
        load_setting(32'd1000, 32'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_event(REQ_OPEN, 32'd0, 2'd0, 4'd0);
        send_event(REQ_SET_POS, 32'hFFFF_FFFB, 2'd0, 4'd0);
        send_event(REQ_OPEN, 32'd0, 2'd0, 4'd0);
        send_event(REQ_MARK_CLOSED, 32'd0, 2'd0, 4'd0);
        send_event(REQ_OPEN, 32'd0, 2'd0, 4'd0);
        send_event(REQ_MARK_OPEN, 32'd0, 2'd0, 4'd0);
        send_event(REQ_SET_POS, 32'd7, 2'd1, 4'd0);
        send_event(REQ_CLOSE, 32'd0, 2'd0, 4'd0);
        send_event(REQ_STOP, 32'd500, 2'd0, 4'd0);
        send_event(REQ_STOP, 32'd1, 2'd0, 4'd0);
        send_event(REQ_CLOSE, 32'd0, 2'd0, 4'd0);
        send_event(REQ_TARGET, 32'h8000_0000, 2'd0, 4'd0);
        send_event(REQ_OPEN, 32'd0, 2'd0, 4'd0);
        send_event(REQ_TARGET, 32'h7FFF_FFFF, 2'd0, 4'd0);
        send_event(REQ_SET_POS, 32'd0, 2'd3, 4'd0);
        send_event(REQ_SET_POS, 32'd1000, 2'd2, 4'd0);
        send_event(REQ_SET_POS, 32'd999, 2'd1, 4'd0);
        send_event(REQ_OPEN, 32'd0, 2'd0, 4'd0);
        send_event(REQ_FAULT, 32'd0, 2'd0, 4'd15);
        send_event(REQ_TARGET, 32'd3, 2'd0, 4'd0);
        send_event(REQ_MARK_OPEN, 32'd0, 2'd0, 4'd0);
        settle_results();

        // widest span, smallest limits
        load_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd1);
        run_random(190);
        settle_results();

        // equal ends
        load_setting(32'd77, 32'd77, 32'd5, 32'd5);
        run_random(80);
        settle_results();

        // ends swapped
        load_setting(32'hFFFF_FFFB, 32'd5, 32'd5, 32'd5);
        run_random(80);
        settle_results();

        // pulse limit with only the unused top bit set
        load_setting(32'd1000, 32'd0, 32'h8000_0000, 32'd9);
        run_random(80);
        settle_results();

        // zero time limit
        load_setting(32'd1000, 32'd0, 32'd9, 32'd0);
        run_random(80);

        for (int phase = 0; phase < 7; phase++) begin
            settle_results();
            load_random_setting();
            calm <= (phase == 3);
            run_random(190);
        end
        calm <= 1'b0;
        settle_results();

        sb.report_leftover();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/dmsc_pkg.sv
rtl/dmsc_step.sv
rtl/door_motion_state_controller_core.sv
bench/door_status_scoreboard_pkg.sv
bench/door_motion_state_controller_core_test.sv
